// File: sv/sawa_pkg.sv
// Shared types, codes and helpers of the stop-and-wait ARQ unit.
`timescale 1ns / 1ps
package sawa_pkg;

  localparam int NBYTES      = 5;
  localparam int MAX_PAYLOAD = 5;
  localparam int LEN_CAP_INT = (MAX_PAYLOAD < NBYTES) ? MAX_PAYLOAD : NBYTES;
  localparam logic [2:0] LEN_CAP = 3'(LEN_CAP_INT);

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SEND = 2'd1;
  localparam logic [1:0] OP_RX   = 2'd2;

  localparam logic [7:0]  HDR_ACK  = 8'd3;
  localparam logic [2:0]  ACK_LEN  = 3'd2;
  localparam logic [15:0] AGE_MAX  = 16'hFFFF;

  localparam int          CFG_IDX_W         = 8;
  localparam logic [7:0]  CFG_RETX_TIMEOUT  = 8'd0;
  localparam logic [7:0]  CFG_ACK_DELAY     = 8'd1;
  localparam logic [15:0] RETX_TIMEOUT_RST  = 16'd1000;
  localparam logic [15:0] ACK_DELAY_RST     = 16'd100;

  localparam int          FIFO_DEPTH = 4;
  localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [NBYTES-1:0][7:0] bytes_t;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] tx_len;
    logic [7:0] tx_b0;
    logic [7:0] tx_b1;
    logic [7:0] tx_b2;
    logic [7:0] tx_b3;
    logic [7:0] tx_b4;
    logic       tx_want_ack;
    logic [7:0] rx_id;
    logic [7:0] rx_header;
    logic [7:0] rx_ack_id;
  } in_item_t;

  typedef struct packed {
    logic       frame_valid;
    logic [7:0] frame_id;
    logic [2:0] frame_len;
    logic [7:0] frame_b0;
    logic [7:0] frame_b1;
    logic [7:0] frame_b2;
    logic [7:0] frame_b3;
    logic [7:0] frame_b4;
    logic       send_busy;
    logic       last;
  } out_item_t;

  // results produced by one item, r0 goes out first
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  // builds a result; bytes at or past len read as zero
  function automatic out_item_t make_result(input logic valid, input logic [7:0] id,
                                            input logic [2:0] len, input bytes_t b,
                                            input logic busy, input logic last);
    out_item_t r;
    bytes_t    m;
    for (int i = 0; i < NBYTES; i++) begin
      m[i] = (3'(i) < len) ? b[i] : 8'd0;
    end
    r.frame_valid = valid;
    r.frame_id    = id;
    r.frame_len   = len;
    r.frame_b0    = m[0];
    r.frame_b1    = m[1];
    r.frame_b2    = m[2];
    r.frame_b3    = m[3];
    r.frame_b4    = m[4];
    r.send_busy   = busy;
    r.last        = last;
    return r;
  endfunction

  function automatic logic [15:0] age_inc(input logic [15:0] a);
    return (a == AGE_MAX) ? a : a + 16'd1;
  endfunction

endpackage

// File: sv/sawa_fifo.sv
// Result queue: takes up to two results per cycle, hands out one.
`timescale 1ns / 1ps
module sawa_fifo
  import sawa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  push_t                 push_i,
  output logic [FIFO_AW:0]      count_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  out_item_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] head_q, head_d;
  logic [FIFO_AW-1:0] tail_q, tail_d;
  logic [FIFO_AW:0]   count_q, count_d;
  logic               pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[head_q];
  assign count_o     = count_q;

  always_comb begin
    head_d  = head_q + FIFO_AW'(pop);
    tail_d  = tail_q + FIFO_AW'(push_i.cnt);
    count_d = count_q + (FIFO_AW+1)'(push_i.cnt) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[tail_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[tail_q + FIFO_AW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

// File: sv/sawa_core.sv
// Registered input item, link state and the per-item decision logic.
`timescale 1ns / 1ps
module sawa_core
  import sawa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_accept_i,
  input  in_item_t             in_data_i,
  input  logic                 cfg_accept_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output logic                 busy_o,
  output push_t                push_o
);

  logic        item_vld_q;
  in_item_t    item_q;

  logic [15:0] retx_timeout_q, ack_delay_q;

  logic [7:0]  next_id_q, next_id_d;
  logic        wait_valid_q, wait_valid_d;
  logic [7:0]  wait_id_q, wait_id_d;
  logic [2:0]  wait_len_q, wait_len_d;
  bytes_t      wait_bytes_q, wait_bytes_d;
  logic [15:0] wait_age_q, wait_age_d;
  logic        ack_pending_q, ack_pending_d;
  logic [7:0]  ack_id_q, ack_id_d;
  logic [15:0] ack_age_q, ack_age_d;

  logic [15:0] wait_age_inc, ack_age_inc;
  logic        ack_fire, retx_fire;
  logic [2:0]  tx_len_c;
  bytes_t      tx_bytes, ack_bytes;
  out_item_t   ack_res, retx_res, send_res;

  assign busy_o = item_vld_q;

  always_comb begin
    wait_age_inc = age_inc(wait_age_q);
    ack_age_inc  = age_inc(ack_age_q);
    ack_fire     = ack_pending_q && (ack_age_inc >= ack_delay_q);
    retx_fire    = wait_valid_q && (wait_age_inc >= retx_timeout_q);

    tx_len_c = item_q.tx_len;
    if (tx_len_c == 3'd0) begin
      tx_len_c = 3'd1;
    end else if (tx_len_c > LEN_CAP) begin
      tx_len_c = LEN_CAP;
    end
    tx_bytes  = {item_q.tx_b4, item_q.tx_b3, item_q.tx_b2, item_q.tx_b1, item_q.tx_b0};
    ack_bytes = '0;
    ack_bytes[0] = HDR_ACK;
    ack_bytes[1] = ack_id_q;

    ack_res  = make_result(1'b1, next_id_q, ACK_LEN, ack_bytes, 1'b0, !retx_fire);
    retx_res = make_result(1'b1, wait_id_q, wait_len_q, wait_bytes_q, 1'b0, 1'b1);
    if (wait_valid_q) begin
      send_res = make_result(1'b0, 8'd0, 3'd0, '0, 1'b1, 1'b1);
    end else begin
      send_res = make_result(1'b1, next_id_q, tx_len_c, tx_bytes, 1'b0, 1'b1);
    end

    next_id_d     = next_id_q;
    wait_valid_d  = wait_valid_q;
    wait_id_d     = wait_id_q;
    wait_len_d    = wait_len_q;
    wait_bytes_d  = wait_bytes_q;
    wait_age_d    = wait_age_q;
    ack_pending_d = ack_pending_q;
    ack_id_d      = ack_id_q;
    ack_age_d     = ack_age_q;
    push_o        = '0;

    if (item_vld_q) begin
      case (item_q.op)
        OP_TICK: begin
          wait_age_d = retx_fire ? 16'd0 : wait_age_inc;
          ack_age_d  = ack_age_inc;
          if (ack_fire) begin
            next_id_d     = next_id_q + 8'd1;
            ack_pending_d = 1'b0;
            push_o.r0     = ack_res;
            push_o.r1     = retx_res;
            push_o.cnt    = retx_fire ? 2'd2 : 2'd1;
          end else if (retx_fire) begin
            push_o.r0  = retx_res;
            push_o.cnt = 2'd1;
          end
        end
        OP_SEND: begin
          push_o.r0  = send_res;
          push_o.cnt = 2'd1;
          if (!wait_valid_q) begin
            next_id_d = next_id_q + 8'd1;
            if (item_q.tx_want_ack) begin
              wait_valid_d = 1'b1;
              wait_id_d    = next_id_q;
              wait_len_d   = tx_len_c;
              for (int i = 0; i < NBYTES; i++) begin
                wait_bytes_d[i] = (3'(i) < tx_len_c) ? tx_bytes[i] : 8'd0;
              end
              wait_age_d   = 16'd0;
            end
          end
        end
        OP_RX: begin
          if (item_q.rx_header == HDR_ACK && wait_valid_q
              && item_q.rx_ack_id == wait_id_q) begin
            wait_valid_d = 1'b0;
          end
          if (item_q.rx_header < HDR_ACK) begin
            ack_pending_d = 1'b1;
            ack_id_d      = item_q.rx_id;
            ack_age_d     = 16'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      item_q <= in_data_i;
    end
    wait_bytes_q <= wait_bytes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q     <= 1'b0;
      retx_timeout_q <= RETX_TIMEOUT_RST;
      ack_delay_q    <= ACK_DELAY_RST;
      next_id_q      <= '0;
      wait_valid_q   <= 1'b0;
      wait_id_q      <= '0;
      wait_len_q     <= '0;
      wait_age_q     <= '0;
      ack_pending_q  <= 1'b0;
      ack_id_q       <= '0;
      ack_age_q      <= '0;
    end else begin
      item_vld_q    <= in_accept_i;
      next_id_q     <= next_id_d;
      wait_valid_q  <= wait_valid_d;
      wait_id_q     <= wait_id_d;
      wait_len_q    <= wait_len_d;
      wait_age_q    <= wait_age_d;
      ack_pending_q <= ack_pending_d;
      ack_id_q      <= ack_id_d;
      ack_age_q     <= ack_age_d;
      if (cfg_accept_i) begin
        case (cfg_index_i)
          CFG_RETX_TIMEOUT: retx_timeout_q <= cfg_data_i;
          CFG_ACK_DELAY:    ack_delay_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  // two results in one item only on a tick: the ACK first, then the resend
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> item_q.op == OP_TICK && push_o.r0.frame_b0 == HDR_ACK
                           && !push_o.r0.last && push_o.r1.last)
    else $error("bad result pair");
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd1 |-> push_o.r0.last)
    else $error("single result without last");
  // a send while a frame is kept must be rejected and leave next_id alone
  a_busy_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && item_q.op == OP_SEND && wait_valid_q
      |=> $stable(next_id_q) && $stable(wait_id_q))
    else $error("send accepted while a frame awaits acknowledgement");
  // a resend restarts the age counter
  a_retx_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && item_q.op == OP_TICK && retx_fire |=> wait_age_q == 16'd0)
    else $error("age not cleared after resend");
`endif

endmodule

// File: sv/stop_and_wait_arq_delayed_ack_unit.sv
// Top level of the stop-and-wait ARQ link unit with a delayed acknowledgement.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction per item:
// a millisecond tick, a send request or a received frame.
// Output channel (out_valid_o/out_ready_i/out_data_o): result transactions;
// a send gives one, a tick zero to two (ACK frame first), a received frame
// none. The final result of an item carries last.
// Config channel (cfg_valid_i/cfg_ready_o): always ready; index 0 sets the
// retransmit timeout, index 1 the ACK delay. Other indexes are ignored.
// Pipeline: an item is registered, decided in the next cycle and its results
// enter a 4-entry result queue, from which the first result is presented.
// Items are taken one per cycle while the queue has room for two
// results; the output drains one result per cycle while out_ready_i is high,
// so ticks that yield two results cannot be sustained at one item per cycle.
// Reset clears the link state and queue and loads the default timeouts.
// When the receiver stalls, the queue fills and in_ready_o drops until it has
// room for the results of the item in flight plus two more.
`timescale 1ns / 1ps
module stop_and_wait_arq_delayed_ack_unit
  import sawa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  logic             in_accept;
  logic             core_busy;
  push_t            push;
  logic [FIFO_AW:0] fifo_count;
  logic [FIFO_AW:0] pending;

  // reserve two queue slots for the next item on top of what is in flight
  assign pending     = core_busy ? (FIFO_AW+1)'(push.cnt) : '0;
  assign in_ready_o  = (fifo_count + pending) <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  sawa_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_accept_i  (in_accept),
    .in_data_i    (in_data_i),
    .cfg_accept_i (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .busy_o       (core_busy),
    .push_o       (push)
  );

  sawa_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .count_o     (fifo_count),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overflow");
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> fifo_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2))
    else $error("item accepted without room for its results");
`endif

endmodule
